@@ sv/rgbcm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the RGB colour matrix: pixel word types, register indexes
// and channel limits. No dependencies.
package rgbcm_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned RowW      = 3 * CoefW;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [ChanW-1:0] ChanMax8 = 8'd255;
  localparam logic [ChanW-1:0] ChanMax5 = 8'd31;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RED_ROW   = 2'd0,
    REG_GREEN_ROW = 2'd1,
    REG_BLUE_ROW  = 2'd2,
    REG_FIVE_BIT  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
  } pix_out_t;

endpackage

@@ sv/rgb_color_matrix.sv @@
`timescale 1ns / 1ps
// RGB colour matrix: four-stage pipeline (products, row sums, reciprocal
// multiply, clamp). Depends on rgbcm_pkg.
// An accepted word passes the product, sum, multiply and output registers.
// Throughput: one word per cycle; each stage holds only while the stage
// after it is full and stalled, so a bubble anywhere is filled at once.
// The divide by the scale factor is a constant-reciprocal multiply.
// Reset: valid bits clear, coefficients return to the identity matrix and
// 8-bit channel mode.
module rgb_color_matrix #(
  parameter int unsigned SCALE_DIVISOR = 1000
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rgbcm_pkg::pix_in_t         in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rgbcm_pkg::pix_out_t        out_word_o,
  input  logic                       cfg_we_i,
  input  logic [rgbcm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rgbcm_pkg::RowW-1:0] cfg_data_i
);
  import rgbcm_pkg::*;

  // Product of an 8-bit unsigned channel and a 16-bit coefficient fits 24 bits
  localparam int unsigned PrdW    = 24;
  // Sum of three products: magnitude below 2^25, plus sign
  localparam int unsigned SumW    = 26;
  localparam int unsigned MagW    = SumW - 1;
  localparam int unsigned DivShift = MagW + $clog2(SCALE_DIVISOR);
  localparam int unsigned RecipW  = MagW + 1;
  localparam longint unsigned RecipFull =
    ((64'd1 << DivShift) + SCALE_DIVISOR - 1) / SCALE_DIVISOR;
  localparam logic [RecipW-1:0] Recip = RecipFull[RecipW-1:0];
  localparam int unsigned MulW    = MagW + RecipW;
  localparam logic [CoefW-1:0] UnitCoef = SCALE_DIVISOR[CoefW-1:0];

  // Configuration registers
  logic [RowW-1:0] row_q [NumChan];
  logic            five_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= {{(2*CoefW){1'b0}}, UnitCoef};
      row_q[1] <= {{CoefW{1'b0}}, UnitCoef, {CoefW{1'b0}}};
      row_q[2] <= {UnitCoef, {(2*CoefW){1'b0}}};
      five_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_RED_ROW:   row_q[0] <= cfg_data_i;
        REG_GREEN_ROW: row_q[1] <= cfg_data_i;
        REG_BLUE_ROW:  row_q[2] <= cfg_data_i;
        REG_FIVE_BIT:  five_q   <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  // Handshake: a stage takes a new word when empty or when it drains
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: mask channels in five-bit mode, nine products
  logic [ChanW-1:0] chan [NumChan];
  logic signed [PrdW-1:0] prd_d [NumChan][NumChan];
  logic signed [PrdW-1:0] prd_q [NumChan][NumChan];
  logic                   five1_q;

  always_comb begin
    chan[0] = in_word_i.in_red;
    chan[1] = in_word_i.in_green;
    chan[2] = in_word_i.in_blue;
    if (five_q) begin
      for (int c = 0; c < NumChan; c++) begin
        chan[c] = {3'b000, chan[c][4:0]};
      end
    end
  end

  for (genvar r = 0; r < NumChan; r++) begin : g_row
    for (genvar c = 0; c < NumChan; c++) begin : g_col
      logic signed [PrdW:0] full;
      assign full = $signed({1'b0, chan[c]}) * $signed(row_q[r][c*CoefW +: CoefW]);
      assign prd_d[r][c] = full[PrdW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      prd_q   <= prd_d;
      five1_q <= five_q;
    end
  end

  // Stage 2: row sums
  logic signed [SumW-1:0] sum_d [NumChan];
  logic signed [SumW-1:0] sum_q [NumChan];
  logic                   five2_q;

  always_comb begin
    for (int r = 0; r < NumChan; r++) begin
      sum_d[r] = SumW'(prd_q[r][0]) + SumW'(prd_q[r][1]) + SumW'(prd_q[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      sum_q   <= sum_d;
      five2_q <= five1_q;
    end
  end

  // Stage 3: quotient by reciprocal; negative sums clamp to zero later
  logic [MulW-1:0] mul_d [NumChan];
  logic [MulW-1:0] mul_q [NumChan];
  logic            neg_q [NumChan];
  logic            five3_q;

  always_comb begin
    for (int r = 0; r < NumChan; r++) begin
      mul_d[r] = MulW'(sum_q[r][MagW-1:0]) * MulW'(Recip);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      mul_q   <= mul_d;
      five3_q <= five2_q;
      for (int r = 0; r < NumChan; r++) begin
        neg_q[r] <= sum_q[r][SumW-1];
      end
    end
  end

  // Stage 4: clamp into the channel range, output register
  logic [ChanW-1:0] res [NumChan];
  logic [MulW-1:0]  shf [NumChan];
  logic [MagW-1:0]  quo [NumChan];
  logic [ChanW-1:0] top;
  pix_out_t         out_q;

  always_comb begin
    top = five3_q ? ChanMax5 : ChanMax8;
    for (int r = 0; r < NumChan; r++) begin
      shf[r] = mul_q[r] >> DivShift;
      quo[r] = shf[r][MagW-1:0];
      if (neg_q[r]) begin
        res[r] = '0;
      end else if (quo[r] > MagW'(top)) begin
        res[r] = top;
      end else begin
        res[r] = quo[r][ChanW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      out_q.out_red   <= res[0];
      out_q.out_green <= res[1];
      out_q.out_blue  <= res[2];
    end
  end

  assign out_valid_o = v4_q;
  assign out_word_o  = out_q;

endmodule

@@ sv/rgbcm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the RGB colour matrix, bound to the top level.
// Depends on rgbcm_pkg.
module rgbcm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input rgbcm_pkg::pix_out_t        out_word_o
);
  import rgbcm_pkg::*;

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word dropped or changed while stalled");

  // An empty output stage means the whole pipe can take a word
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

  // With no back-pressure an accepted word reaches the output stage
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
    |=> out_valid_o)
    else $error("word did not reach output in four cycles");

  // Nothing appears out of an empty pipe
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_o) && !out_valid_o ##1 !out_valid_o
    ##1 !out_valid_o ##1 !out_valid_o |=> !out_valid_o || $past(in_valid_i, 3)
    || $past(in_valid_i, 2) || $past(in_valid_i, 4))
    else $error("output word without an input word");

endmodule

bind rgb_color_matrix rgbcm_checker u_rgbcm_checker (.*);
